// ===== rtl/mbs_pkg.sv =====
// shared types and constants of the mean background subtractor
package mbs_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned SUM_W = 16;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned NCH   = 3;

  localparam logic [10:0] WEIGHT_B   = 11'd1868;
  localparam logic [13:0] WEIGHT_G   = 14'd9617;
  localparam logic [12:0] WEIGHT_R   = 13'd4899;
  localparam int unsigned GRAY_SHIFT = 14;
  localparam logic [22:0] GRAY_HALF  = 23'd8192;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 3'd0,
    CMD_ACC   = 3'd1,
    CMD_FIN   = 3'd2,
    CMD_MIN   = 3'd3,
    CMD_SUB   = 3'd4,
    CMD_TSUB  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_GRAY
  } state_e;

  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;
  typedef logic [NCH-1:0][PIX_W-1:0] pix3_t;

endpackage

// ===== rtl/mbs_in_if.sv =====
// input channel carrying one pixel command word
interface mbs_in_if;
  logic                                valid;
  logic                                ready;
  logic [mbs_pkg::CMD_W-1:0]           cmd;
  logic [mbs_pkg::IDX_W-1:0]           pixel_index;
  logic [mbs_pkg::PIX_W-1:0]           blue_in;
  logic [mbs_pkg::PIX_W-1:0]           green_in;
  logic [mbs_pkg::PIX_W-1:0]           red_in;
  logic [mbs_pkg::PIX_W-1:0]           gray_in;
  logic                                last_pixel;

  modport source (
    output valid, cmd, pixel_index, blue_in, green_in, red_in, gray_in, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, cmd, pixel_index, blue_in, green_in, red_in, gray_in, last_pixel,
    output ready
  );
endinterface

// ===== rtl/mbs_out_if.sv =====
// output channel carrying one foreground word
interface mbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbs_pkg::PIX_W-1:0]   out_pixel;
  logic                        background_ready;

  modport source (output valid, out_pixel, background_ready, input ready);
  modport sink (input valid, out_pixel, background_ready, output ready);
endinterface

// ===== rtl/mbs_ram.sv =====
// generic single write port ram with registered read
module mbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/mbs_div.sv =====
// three lane restoring divider with round half to even and 8 bit saturation
module mbs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  mbs_pkg::sums_t               sum_i,
  input  logic [mbs_pkg::CNT_W-1:0]    count_i,
  output logic                         done_o,
  output mbs_pkg::pix3_t               mean_o
);

  logic                                busy_q;
  logic                                fin_q;
  logic                                done_q;
  logic [3:0]                          cnt_q;
  logic [mbs_pkg::CNT_W-1:0]           div_q;
  mbs_pkg::sums_t                      quo_q;
  mbs_pkg::sums_t                      quo_d;
  logic [mbs_pkg::NCH-1:0][mbs_pkg::CNT_W-1:0] rem_q;
  logic [mbs_pkg::NCH-1:0][mbs_pkg::CNT_W-1:0] rem_d;
  mbs_pkg::pix3_t                      mean_d;
  mbs_pkg::pix3_t                      mean_q;

  // one quotient bit per lane per cycle
  always_comb begin
    logic [mbs_pkg::CNT_W:0]   rem_sh;
    logic [mbs_pkg::CNT_W+1:0] rem2;
    logic [mbs_pkg::SUM_W:0]   q_rnd;
    logic                      up;
    for (int c = 0; c < mbs_pkg::NCH; c++) begin
      rem_sh = {rem_q[c], quo_q[c][mbs_pkg::SUM_W-1]};
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d[c] = mbs_pkg::CNT_W'(rem_sh - {1'b0, div_q});
        quo_d[c] = {quo_q[c][mbs_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_d[c] = rem_sh[mbs_pkg::CNT_W-1:0];
        quo_d[c] = {quo_q[c][mbs_pkg::SUM_W-2:0], 1'b0};
      end
      rem2  = {1'b0, rem_q[c], 1'b0};
      up    = (rem2 > {2'b00, div_q}) ||
              ((rem2 == {2'b00, div_q}) && quo_q[c][0]);
      q_rnd = {1'b0, quo_q[c]} + {{mbs_pkg::SUM_W{1'b0}}, up};
      mean_d[c] = (q_rnd > (mbs_pkg::SUM_W+1)'(255)) ? 8'hff : q_rnd[mbs_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && (cnt_q == 4'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd15;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= sum_i;
      rem_q <= '0;
      div_q <= (count_i > 8'd1) ? count_i : 8'd1;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (fin_q) begin
      mean_q <= mean_d;
    end
  end

  assign done_o = done_q;
  assign mean_o = mean_q;

endmodule

// ===== rtl/mbs_gray.sv =====
// two stage bt.601 weighted gray conversion
module mbs_gray (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  mbs_pkg::pix3_t              mean_i,
  output logic                        valid_o,
  output logic [mbs_pkg::PIX_W-1:0]   gray_o
);

  logic        v1_q;
  logic        v2_q;
  logic [18:0] pb_q;
  logic [21:0] pg_q;
  logic [20:0] pr_q;
  logic [22:0] acc;
  logic [8:0]  y;
  logic [mbs_pkg::PIX_W-1:0] gray_q;

  assign acc = 23'(pb_q) + 23'(pg_q) + 23'(pr_q) + mbs_pkg::GRAY_HALF;
  assign y   = acc[mbs_pkg::GRAY_SHIFT+8:mbs_pkg::GRAY_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pb_q <= 19'(mean_i[0]) * 19'(mbs_pkg::WEIGHT_B);
      pg_q <= 22'(mean_i[1]) * 22'(mbs_pkg::WEIGHT_G);
      pr_q <= 21'(mean_i[2]) * 21'(mbs_pkg::WEIGHT_R);
    end
    if (v1_q) begin
      gray_q <= y[8] ? 8'hff : y[7:0];
    end
  end

  assign valid_o = v2_q;
  assign gray_o  = gray_q;

endmodule

// ===== rtl/mean_background_subtractor_core.sv =====
// top level of the mean background subtractor
//
//  port         dir  words                              handshake
//  in_i         in   cmd, index, bgr, gray, last        valid/ready
//  out_o        out  foreground pixel, ready flag       valid/ready
//  threshold_*  in   threshold register                 write enable only
//
// start, accumulate, min update, subtract: accept, then memory read
// finalize: the 16 step divider, its rounding step and the gray stages
// no clearing pass after reset; memories are undefined until written
// a subtract result waits in the memory read cycle while the output word is held
module mean_background_subtractor_core #(
  parameter int unsigned PIXELS     = 65536,
  parameter int unsigned MAX_FRAMES = 255
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mbs_in_if.sink                      in_i,
  mbs_out_if.source                   out_o,
  input  logic                        threshold_we_i,
  input  logic [mbs_pkg::PIX_W-1:0]   threshold_i
);

  localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned SW = mbs_pkg::NCH * mbs_pkg::SUM_W;

  mbs_pkg::state_e               state_q, state_d;
  mbs_pkg::cmd_e                 cmd_q;
  logic [mbs_pkg::IDX_W-1:0]     idx_q;
  mbs_pkg::pix3_t                chan_q;
  logic [mbs_pkg::PIX_W-1:0]     gray_q;
  logic                          last_q;
  logic [mbs_pkg::CNT_W-1:0]     fc_q, fc_d;
  logic                          ready_q, ready_d;
  logic [mbs_pkg::PIX_W-1:0]     thr_q;
  logic                          out_valid_q;
  logic [mbs_pkg::PIX_W-1:0]     out_pixel_q, out_pixel_d;
  logic                          out_bgr_q;

  logic                          accept;
  logic                          out_load;
  logic [31:0]                   rd_ext, wr_ext;
  logic                          in_range;
  logic [AW-1:0]                 rd_addr, wr_addr;

  logic                          sum_we;
  mbs_pkg::sums_t                sum_rd, sum_wr;
  logic                          bg_we;
  logic [mbs_pkg::PIX_W-1:0]     bg_rd, bg_wr, bg;

  logic                          div_start, div_done;
  mbs_pkg::pix3_t                mean;
  logic                          gray_valid;
  logic [mbs_pkg::PIX_W-1:0]     gray_bg;

  logic signed [9:0]             diff;
  logic signed [9:0]             td;

  assign in_i.ready = (state_q == mbs_pkg::S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign rd_ext   = 32'(in_i.pixel_index);
  assign rd_addr  = rd_ext[AW-1:0];
  assign wr_ext   = 32'(idx_q);
  assign wr_addr  = wr_ext[AW-1:0];
  assign in_range = wr_ext < 32'(PIXELS);
  assign bg       = in_range ? bg_rd : '0;

  mbs_ram #(.WIDTH(SW), .DEPTH(PIXELS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (wr_addr),
    .wdata_i (SW'(sum_wr)),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (sum_rd)
  );

  mbs_ram #(.WIDTH(mbs_pkg::PIX_W), .DEPTH(PIXELS)) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (bg_we),
    .waddr_i (wr_addr),
    .wdata_i (bg_wr),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (bg_rd)
  );

  mbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_rd),
    .count_i (fc_q),
    .done_o  (div_done),
    .mean_o  (mean)
  );

  mbs_gray u_gray (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_done),
    .mean_i  (mean),
    .valid_o (gray_valid),
    .gray_o  (gray_bg)
  );

  // saturating accumulate, overwrite on first frame
  always_comb begin
    logic [mbs_pkg::SUM_W:0] s;
    for (int c = 0; c < mbs_pkg::NCH; c++) begin
      s = {1'b0, sum_rd[c]} + (mbs_pkg::SUM_W+1)'(chan_q[c]);
      if (fc_q == '0) begin
        sum_wr[c] = mbs_pkg::SUM_W'(chan_q[c]);
      end else begin
        sum_wr[c] = s[mbs_pkg::SUM_W] ? '1 : s[mbs_pkg::SUM_W-1:0];
      end
    end
  end

  assign diff = $signed({2'b00, gray_q}) - $signed({2'b00, bg});
  assign td   = ($signed({2'b00, thr_q}) >= $signed({2'b00, bg})) ?
                ($signed({2'b00, thr_q}) - $signed({2'b00, bg})) :
                ($signed({2'b00, bg}) - $signed({2'b00, thr_q}));

  always_comb begin
    out_pixel_d = gray_q;
    if (ready_q) begin
      if (cmd_q == mbs_pkg::CMD_SUB) begin
        out_pixel_d = (bg > gray_q) ? (bg - gray_q) : '0;
      end else if (diff <= td) begin
        out_pixel_d = '0;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    fc_d      = fc_q;
    ready_d   = ready_q;
    sum_we    = 1'b0;
    bg_we     = 1'b0;
    bg_wr     = gray_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      mbs_pkg::S_IDLE: begin
        if (accept) begin
          state_d = mbs_pkg::S_EXEC;
        end
      end
      mbs_pkg::S_EXEC: begin
        state_d = mbs_pkg::S_IDLE;
        unique case (cmd_q) inside
          mbs_pkg::CMD_START: begin
            fc_d = '0;
          end
          mbs_pkg::CMD_ACC: begin
            if (fc_q < mbs_pkg::CNT_W'(MAX_FRAMES)) begin
              sum_we = in_range;
              if (last_q) begin
                fc_d = fc_q + 8'd1;
              end
            end
          end
          mbs_pkg::CMD_FIN: begin
            if (in_range) begin
              div_start = 1'b1;
              state_d   = mbs_pkg::S_DIV;
            end else if (last_q) begin
              ready_d = 1'b1;
            end
          end
          mbs_pkg::CMD_MIN: begin
            bg_we = in_range && (gray_q < bg);
          end
          mbs_pkg::CMD_SUB, mbs_pkg::CMD_TSUB: begin
            if (!out_valid_q || out_o.ready) begin
              out_load = 1'b1;
            end else begin
              state_d = mbs_pkg::S_EXEC;
            end
          end
          default: begin
          end
        endcase
      end
      mbs_pkg::S_DIV: begin
        if (div_done) begin
          state_d = mbs_pkg::S_GRAY;
        end
      end
      mbs_pkg::S_GRAY: begin
        if (gray_valid) begin
          bg_we   = 1'b1;
          bg_wr   = gray_bg;
          state_d = mbs_pkg::S_IDLE;
          if (last_q) begin
            ready_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = mbs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbs_pkg::S_IDLE;
      fc_q        <= '0;
      ready_q     <= 1'b0;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fc_q    <= fc_d;
      ready_q <= ready_d;
      if (threshold_we_i) begin
        thr_q <= threshold_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= mbs_pkg::cmd_e'(in_i.cmd);
      idx_q     <= in_i.pixel_index;
      chan_q[0] <= in_i.blue_in;
      chan_q[1] <= in_i.green_in;
      chan_q[2] <= in_i.red_in;
      gray_q    <= in_i.gray_in;
      last_q    <= in_i.last_pixel;
    end
    if (out_load) begin
      out_pixel_q <= out_pixel_d;
      out_bgr_q   <= ready_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.out_pixel        = out_pixel_q;
  assign out_o.background_ready = out_bgr_q;

endmodule
